@@ design/mebc_pkg.sv @@
// ----------------------------------------------------------------------------
// mebc_pkg
// Shared constants, types and helpers for the minimum-error boundary cut.
// ----------------------------------------------------------------------------
package mebc_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 16;
    localparam int COST_BITS   = 32;

    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLUMNS);
    localparam int CHAN_W     = 8;
    localparam int ERR_W      = 2 * CHAN_W + 2;
    localparam int MOVE_AW    = ROW_W + COL_W;
    localparam int MOVE_DEPTH = MAX_ROWS << COL_W;

    localparam int ROW_COUNT_W = 7;
    localparam int COL_COUNT_W = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = CFG_INDEX_W'(1);

    localparam logic [1:0] MOVE_STAY  = 2'b00;
    localparam logic [1:0] MOVE_RIGHT = 2'b01;
    localparam logic [1:0] MOVE_LEFT  = 2'b11;

    typedef struct packed {
        logic [CHAN_W-1:0] first_red;
        logic [CHAN_W-1:0] first_green;
        logic [CHAN_W-1:0] first_blue;
        logic [CHAN_W-1:0] second_red;
        logic [CHAN_W-1:0] second_green;
        logic [CHAN_W-1:0] second_blue;
    } t_pixel;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // pixel transfer this cycle
        logic walk_load;  // start walk at last row, best column
        logic walk_step;  // seam result transferred, move up one row
        logic restart;    // region finished
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_pixel;     // pixel now offered is the last of the region
        logic walk_row_zero;  // walk has reached row zero
    } t_status;

    // last row index in use, count clamped to [2, MAX_ROWS]
    function automatic logic [ROW_W-1:0] last_row_of(input logic [ROW_COUNT_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 2) n = 2;
        if (n > MAX_ROWS) n = MAX_ROWS;
        return ROW_W'(n - 1);
    endfunction

    // last column index in use, count clamped to [2, MAX_COLUMNS]
    function automatic logic [COL_W-1:0] last_col_of(input logic [COL_COUNT_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 2) n = 2;
        if (n > MAX_COLUMNS) n = MAX_COLUMNS;
        return COL_W'(n - 1);
    endfunction

endpackage

@@ design/mebc_if.sv @@
// ----------------------------------------------------------------------------
// mebc_if
// Valid/ready channel interfaces: pixel pairs in, seam results out, config.
// ----------------------------------------------------------------------------
interface mebc_pixel_if;
    import mebc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] first_red;
    logic [CHAN_W-1:0] first_green;
    logic [CHAN_W-1:0] first_blue;
    logic [CHAN_W-1:0] second_red;
    logic [CHAN_W-1:0] second_green;
    logic [CHAN_W-1:0] second_blue;

    modport source (output valid, first_red, first_green, first_blue,
                    second_red, second_green, second_blue, input ready);
    modport sink   (input valid, first_red, first_green, first_blue,
                    second_red, second_green, second_blue, output ready);
endinterface

interface mebc_seam_if;
    import mebc_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] seam_column;
    logic [ROW_W-1:0] seam_row;
    logic             seam_last;

    modport source (output valid, seam_column, seam_row, seam_last, input ready);
    modport sink   (input valid, seam_column, seam_row, seam_last, output ready);
endinterface

interface mebc_cfg_if;
    import mebc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/mebc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mebc_ctrl
// Sequencer: pixel streaming, pipeline drain, then the seam walk back.
// ----------------------------------------------------------------------------
module mebc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  mebc_pkg::t_status i_status,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output mebc_pkg::t_cmd    o_cmd
);
    import mebc_pkg::*;

    typedef enum logic [2:0] {
        ST_PIXEL,
        ST_DRAIN,
        ST_LOAD,
        ST_READ,
        ST_SEND
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   accept;
    logic   sent;

    assign accept = i_in_valid & r_in_ready;
    assign sent   = r_out_valid & i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_PIXEL: if (accept && i_status.last_pixel) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_READ;
            ST_READ:  n_state = ST_SEND;
            ST_SEND: begin
                if (sent) n_state = i_status.walk_row_zero ? ST_PIXEL : ST_READ;
            end
            default:  n_state = ST_PIXEL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_PIXEL;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= (n_state == ST_PIXEL);
            r_out_valid <= (n_state == ST_SEND);
        end
    end

    always_comb begin
        o_cmd.accept    = accept;
        o_cmd.walk_load = (r_state == ST_LOAD);
        o_cmd.walk_step = (r_state == ST_SEND) && sent;
        o_cmd.restart   = (r_state == ST_SEND) && sent && i_status.walk_row_zero;
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

@@ design/mebc_dpath.sv @@
// ----------------------------------------------------------------------------
// mebc_dpath
// Error stage, cost/move stage, row cost store, move memory and walk registers.
// ----------------------------------------------------------------------------
module mebc_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mebc_pkg::t_cmd                      i_cmd,
    input  mebc_pkg::t_pixel                    i_pixel,
    input  logic                                i_cfg_we,
    input  logic [mebc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mebc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output mebc_pkg::t_status                   o_status,
    output logic [mebc_pkg::COL_W-1:0]          o_seam_column,
    output logic [mebc_pkg::ROW_W-1:0]          o_seam_row,
    output logic                                o_seam_last
);
    import mebc_pkg::*;

    localparam logic [COST_BITS-1:0] COST_FULL = '1;

    // configuration, held as last index in use
    logic [ROW_W-1:0] r_last_row;
    logic [COL_W-1:0] r_last_col;

    // input position counters
    logic [ROW_W-1:0] r_in_row;
    logic [COL_W-1:0] r_in_col;

    // error stage
    logic             r_s1_valid;
    logic [ERR_W-1:0] r_s1_err;
    logic [ROW_W-1:0] r_s1_row;
    logic [COL_W-1:0] r_s1_col;

    // row costs: one store, overwritten in place; neighbours held in a window
    logic [COST_BITS-1:0] r_costs [MAX_COLUMNS];
    logic [COST_BITS-1:0] r_w_left;
    logic [COST_BITS-1:0] r_w_mid;
    logic [COL_W-1:0]     cost_raddr;
    logic [COST_BITS-1:0] cost_rd;

    logic [COST_BITS-1:0] r_best_cost;
    logic [COL_W-1:0]     r_best_col;

    logic [1:0] r_moves [MOVE_DEPTH];
    logic [1:0] r_move_rd;

    logic [ROW_W-1:0] r_walk_row;
    logic [COL_W-1:0] r_walk_col;

    // cost stage signals
    logic [CHAN_W-1:0]    d_r;
    logic [CHAN_W-1:0]    d_g;
    logic [CHAN_W-1:0]    d_b;
    logic [ERR_W-1:0]     err;
    logic [COST_BITS-1:0] low;
    logic [1:0]           mv;
    logic [COST_BITS:0]   sum;
    logic [COST_BITS-1:0] cost;
    logic                 has_left;
    logic                 has_right;

    logic signed [COL_W+1:0] walk_sum;
    logic [COL_W-1:0]        walk_next;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    assign d_r = abs_diff(i_pixel.first_red,   i_pixel.second_red);
    assign d_g = abs_diff(i_pixel.first_green, i_pixel.second_green);
    assign d_b = abs_diff(i_pixel.first_blue,  i_pixel.second_blue);
    assign err = (ERR_W'(d_r) * ERR_W'(d_r)) + (ERR_W'(d_g) * ERR_W'(d_g))
               + (ERR_W'(d_b) * ERR_W'(d_b));

    assign cost_raddr = (r_s1_col == r_last_col) ? '0 : r_s1_col + 1'b1;
    assign cost_rd    = r_costs[cost_raddr];
    assign has_left   = (r_s1_col != '0);
    assign has_right  = (r_s1_col != r_last_col);

    // leftmost wins ties
    always_comb begin
        low = r_w_mid;
        mv  = MOVE_STAY;
        if (has_left && !(r_w_mid < r_w_left)) begin
            low = r_w_left;
            mv  = MOVE_LEFT;
        end
        if (has_right && (cost_rd < low)) begin
            low = cost_rd;
            mv  = MOVE_RIGHT;
        end
        sum = {1'b0, low} + (COST_BITS + 1)'(r_s1_err);
        if (r_s1_row == '0) begin
            cost = COST_BITS'(r_s1_err);
            mv   = MOVE_STAY;
        end else begin
            cost = sum[COST_BITS] ? COST_FULL : sum[COST_BITS-1:0];
        end
    end

    // walk: next column, clamped to the region
    assign walk_sum = $signed({2'b00, r_walk_col}) + $signed({{COL_W{r_move_rd[1]}}, r_move_rd});
    always_comb begin
        if (walk_sum < 0) begin
            walk_next = '0;
        end else if (walk_sum > $signed({2'b00, r_last_col})) begin
            walk_next = r_last_col;
        end else begin
            walk_next = walk_sum[COL_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_row  <= ROW_W'(MAX_ROWS - 1);
            r_last_col  <= COL_W'(MAX_COLUMNS - 1);
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_s1_valid  <= 1'b0;
            r_best_cost <= COST_FULL;
            r_best_col  <= '0;
        end else begin
            r_s1_valid <= i_cmd.accept;
            if (i_cmd.accept) begin
                if (r_in_col == r_last_col) begin
                    r_in_col <= '0;
                    r_in_row <= (r_in_row == r_last_row) ? '0 : r_in_row + 1'b1;
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end
            if (r_s1_valid && (r_s1_row == r_last_row)
                && ((r_s1_col == '0) || (cost < r_best_cost))) begin
                r_best_cost <= cost;
                r_best_col  <= r_s1_col;
            end
            if (i_cmd.restart) begin
                r_in_row    <= '0;
                r_in_col    <= '0;
                r_best_cost <= COST_FULL;
                r_best_col  <= '0;
            end
            if (i_cfg_we && (i_cfg_index == REG_ROW_COUNT || i_cfg_index == REG_COLUMN_COUNT)) begin
                if (i_cfg_index == REG_ROW_COUNT) begin
                    r_last_row <= last_row_of(i_cfg_data[ROW_COUNT_W-1:0]);
                end else begin
                    r_last_col <= last_col_of(i_cfg_data[COL_COUNT_W-1:0]);
                end
                r_in_row    <= '0;
                r_in_col    <= '0;
                r_best_cost <= COST_FULL;
                r_best_col  <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_s1_err <= err;
            r_s1_row <= r_in_row;
            r_s1_col <= r_in_col;
        end
        if (r_s1_valid) begin
            r_costs[r_s1_col] <= cost;
            r_w_left          <= r_w_mid;
            r_w_mid           <= cost_rd;
        end
        if (i_cmd.walk_load) begin
            r_walk_row <= r_last_row;
            r_walk_col <= r_best_col;
        end else if (i_cmd.walk_step) begin
            r_walk_row <= r_walk_row - 1'b1;
            r_walk_col <= walk_next;
        end
    end

    // move memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) r_moves[{r_s1_row, r_s1_col}] <= mv;
        r_move_rd <= r_moves[{r_walk_row, r_walk_col}];
    end

    assign o_status.last_pixel    = (r_in_row == r_last_row) && (r_in_col == r_last_col);
    assign o_status.walk_row_zero = (r_walk_row == '0);

    assign o_seam_column = r_walk_col;
    assign o_seam_row    = r_walk_row;
    assign o_seam_last   = (r_walk_row == '0);

endmodule

@@ design/min_error_boundary_cut.sv @@
// ----------------------------------------------------------------------------
// min_error_boundary_cut
// Minimum-error boundary cut: streams an overlap of pixel pairs, keeps the
// cumulative cost row and moves, then walks the seam back from the last row.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_pixel   in   valid/ready    first_/second_ red, green, blue (8b each)
//  o_seam    out  valid/ready    seam_column (4b), seam_row (6b), seam_last
//  i_cfg     in   valid/ready    index (0 rows, 1 columns), data (7b)
//
//  Pixels: one transfer a cycle while streaming, rows x columns in total.
//  After the last pixel: a drain and a walk load, then for each seam result
//  a move memory read, then a send, longer while o_seam stalls.
//  No pixel is taken during the walk. i_cfg is always ready; a write restarts
//  the region. Synchronous active-low reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module min_error_boundary_cut (
    input logic          i_clk,
    input logic          i_rst_n,
    mebc_pixel_if.sink   i_pixel,
    mebc_seam_if.source  o_seam,
    mebc_cfg_if.sink     i_cfg
);
    import mebc_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_pixel  pixel;
    logic    cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid & i_cfg.ready;

    assign pixel.first_red    = i_pixel.first_red;
    assign pixel.first_green  = i_pixel.first_green;
    assign pixel.first_blue   = i_pixel.first_blue;
    assign pixel.second_red   = i_pixel.second_red;
    assign pixel.second_green = i_pixel.second_green;
    assign pixel.second_blue  = i_pixel.second_blue;

    // sequencer: streaming, drain, walk
    mebc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pixel.valid),
        .i_out_ready (o_seam.ready),
        .i_status    (status),
        .o_in_ready  (i_pixel.ready),
        .o_out_valid (o_seam.valid),
        .o_cmd       (cmd)
    );

    // cost pipeline, move memory and seam walk
    mebc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_pixel       (pixel),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_status      (status),
        .o_seam_column (o_seam.seam_column),
        .o_seam_row    (o_seam.seam_row),
        .o_seam_last   (o_seam.seam_last)
    );

`ifndef SYNTH
    // the walk and the pixel stream never overlap
    a_no_pixel_during_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_seam.valid |-> !i_pixel.ready)
        else $error("pixel ready while a seam result is pending");

    // each seam transfer but the last moves up exactly one row
    a_row_steps_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_seam.valid && o_seam.ready && !o_seam.seam_last)
        |=> ($past(o_seam.seam_row) == o_seam.seam_row + 1'b1))
        else $error("seam row did not step down by one");

    // last pixel of a region closes the input
    a_last_pixel_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && status.last_pixel) |=> !i_pixel.ready)
        else $error("input still ready after last pixel");
`endif

endmodule
